/* hw/rtl/zpt_pkg.sv */
// Package for the zigzag pivot tracker: default sizes, reset values of the
// configuration registers, event and register codes, and the result record type.
// Depends on nothing.
`timescale 1ns / 1ps

package zpt_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_MAX_DEF    = 64;
  localparam int BACKSTEP_MAX_DEF = 8;
  localparam int PRICE_BITS_DEF   = 32;

  // Depths of the queue between the two halves and of the result queue.
  localparam int REC_Q_DEPTH = 4;
  localparam int EVT_Q_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_WINDOW_DEPTH = 2'd0;
  localparam logic [1:0] REG_BACK_STEP    = 2'd1;
  localparam logic [1:0] REG_TOLERANCE    = 2'd2;

  // Configuration reset values.
  localparam logic [6:0]  WINDOW_DEPTH_RST = 7'd12;
  localparam logic [3:0]  BACK_STEP_RST    = 4'd3;
  localparam logic [15:0] TOLERANCE_RST    = 16'd10;

  // Event kinds.
  localparam logic [1:0] KIND_SET_LOW  = 2'd0;
  localparam logic [1:0] KIND_SET_HIGH = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  // One result record.
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] bar_index;
    logic [31:0] pivot_price;
    logic        last_event;
  } event_t;

endpackage

/* hw/rtl/zpt_fifo.sv */
// Small first-in first-out queue with a combinational read port.
// Used between the front and back halves and for the results. No dependencies.
`timescale 1ns / 1ps

module zpt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/zpt_front.sv */
// Front half of the zigzag pivot tracker: takes bars, scans the window memory,
// marks candidate extremes and hands delayed bars to the cutting stage as records.
// Depends on no package; sizes come by parameter from the top level.
`timescale 1ns / 1ps

module zpt_front #(
  parameter int DMAX = 64,
  parameter int BMAX = 8,
  parameter int PB   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              action,
  input  logic [31:0]       bar_high,
  input  logic [31:0]       bar_low,
  output logic              full,
  input  logic [6:0]        window_depth,
  input  logic [3:0]        back_step,
  input  logic [15:0]       tolerance,
  output logic              rec_push,
  output logic [2*PB+32:0]  rec_data,
  input  logic              rec_full
);

  localparam int AW  = (DMAX > 1) ? $clog2(DMAX) : 1;
  localparam int FW  = $clog2(DMAX + 1);
  localparam int DLY = BMAX + 1;
  localparam int PW  = $clog2(DLY + 1);
  localparam int IW  = $clog2(DLY);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SCAN = 2'd1;
  localparam logic [1:0] F_MARK = 2'd2;
  localparam logic [1:0] F_CUT  = 2'd3;

  typedef struct packed {
    logic [PB-1:0] low_mark;
    logic [PB-1:0] high_mark;
    logic [31:0]   bar_index;
    logic          last_cut;
  } cut_rec_t;

  logic [1:0]      state;
  logic [2*PB-1:0] mem [DMAX];
  logic [2*PB-1:0] rd_data;
  logic            rd_vld;
  logic [AW-1:0]   rd_ptr;
  logic [AW-1:0]   ring_pos;
  logic [FW-1:0]   fill;
  logic [FW-1:0]   issued;
  logic [FW-1:0]   scan_cnt;
  logic [31:0]     bars_seen;
  logic [PB-1:0]   prev_lo;
  logic [PB-1:0]   prev_hi;
  logic [PB-1:0]   cur_l;
  logic [PB-1:0]   cur_h;
  logic [PB-1:0]   mn;
  logic [PB-1:0]   mx;
  logic [PB-1:0]   lmarks [DLY];
  logic [PB-1:0]   hmarks [DLY];
  logic [PW-1:0]   pending;
  logic            flush;

  logic [PB-1:0]   in_h;
  logic [PB-1:0]   in_l;
  logic            accept;
  logic [FW-1:0]   fill_inc;
  logic [FW-1:0]   depth_c;
  logic [FW-1:0]   cnt_c;
  logic [PW-1:0]   bs;
  logic            scan_issue;
  logic            scan_done;
  logic            new_lo;
  logic            new_hi;
  logic            lo_ok;
  logic            hi_ok;
  logic [IW-1:0]   pos;
  logic            cut_more;
  cut_rec_t        rec;

  assign in_h   = PB'(bar_high);
  assign in_l   = PB'(bar_low);
  assign full   = (state != F_IDLE);
  assign accept = push && !full;

  // Window size for this bar, limited by what the ring has seen.
  always_comb begin
    fill_inc = (fill < FW'(DMAX)) ? fill + 1'b1 : fill;
    if (window_depth == '0) begin
      depth_c = FW'(1);
    end else if (32'(window_depth) > 32'(DMAX)) begin
      depth_c = FW'(DMAX);
    end else begin
      depth_c = FW'(window_depth);
    end
    cnt_c = (depth_c < fill_inc) ? depth_c : fill_inc;
    bs    = (32'(back_step) > 32'(BMAX)) ? PW'(BMAX) : PW'(back_step);
  end

  // Scan control: one memory read issued per cycle, its data valid in the next cycle.
  assign scan_issue = (state == F_SCAN) && (issued < scan_cnt);
  assign scan_done  = (state == F_SCAN) && !scan_issue && !rd_vld;

  // Mark qualification against the previous window extremes.
  assign new_lo = (mn != prev_lo);
  assign new_hi = (mx != prev_hi);
  assign lo_ok  = (cur_l - mn) <= PB'(tolerance);
  assign hi_ok  = (mx - cur_h) <= PB'(tolerance);

  // Oldest delayed bar and the record sent to the cutting stage.
  always_comb begin
    pos            = IW'(pending - 1'b1);
    cut_more       = flush ? (pending != '0) : (pending > bs);
    rec.low_mark   = lmarks[pos];
    rec.high_mark  = hmarks[pos];
    rec.bar_index  = bars_seen - 32'(pos) - 32'd1;
    rec.last_cut   = flush ? (pending == PW'(1)) : (pending == bs + 1'b1);
  end

  assign rec_push = (state == F_CUT) && cut_more && !rec_full;
  assign rec_data = rec;

  // Window memory: written when a bar is taken, read during the scan.
  always_ff @(posedge clk) begin
    if (accept && !action) begin
      mem[ring_pos] <= {in_h, in_l};
    end
    if (scan_issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Sequencer, delay line and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      rd_vld    <= 1'b0;
      ring_pos  <= '0;
      fill      <= '0;
      bars_seen <= '0;
      prev_lo   <= '0;
      prev_hi   <= '0;
      pending   <= '0;
      flush     <= 1'b0;
      for (int k = 0; k < DLY; k++) begin
        lmarks[k] <= '0;
        hmarks[k] <= '0;
      end
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (action) begin
              flush <= 1'b1;
              state <= F_CUT;
            end else begin
              flush     <= 1'b0;
              ring_pos  <= (ring_pos == AW'(DMAX - 1)) ? '0 : ring_pos + 1'b1;
              rd_ptr    <= (ring_pos == '0) ? AW'(DMAX - 1) : ring_pos - 1'b1;
              fill      <= fill_inc;
              scan_cnt  <= cnt_c;
              issued    <= FW'(1);
              bars_seen <= bars_seen + 32'd1;
              cur_l     <= in_l;
              cur_h     <= in_h;
              mn        <= in_l;
              mx        <= in_h;
              if (pending < PW'(DLY)) begin
                pending <= pending + 1'b1;
              end
              for (int k = DLY - 1; k > 0; k--) begin
                lmarks[k] <= lmarks[k-1];
                hmarks[k] <= hmarks[k-1];
              end
              lmarks[0] <= '0;
              hmarks[0] <= '0;
              state     <= F_SCAN;
            end
          end
        end
        F_SCAN: begin
          rd_vld <= scan_issue;
          if (scan_issue) begin
            issued <= issued + 1'b1;
            rd_ptr <= (rd_ptr == '0) ? AW'(DMAX - 1) : rd_ptr - 1'b1;
          end
          if (rd_vld) begin
            if (rd_data[PB-1:0] < mn) begin
              mn <= rd_data[PB-1:0];
            end
            if (rd_data[2*PB-1:PB] > mx) begin
              mx <= rd_data[2*PB-1:PB];
            end
          end
          if (scan_done) begin
            state <= F_MARK;
          end
        end
        F_MARK: begin
          // A new extreme within tolerance unmarks weaker recent bars.
          if (new_lo) begin
            prev_lo <= mn;
            if (lo_ok) begin
              for (int b = 1; b <= BMAX; b++) begin
                if (PW'(b) <= bs && PW'(b) < pending && lmarks[b] != '0 &&
                    lmarks[b] > mn) begin
                  lmarks[b] <= '0;
                end
              end
            end
          end
          if (new_hi) begin
            prev_hi <= mx;
            if (hi_ok) begin
              for (int b = 1; b <= BMAX; b++) begin
                if (PW'(b) <= bs && PW'(b) < pending && hmarks[b] != '0 &&
                    hmarks[b] < mx) begin
                  hmarks[b] <= '0;
                end
              end
            end
          end
          lmarks[0] <= (new_lo && lo_ok && cur_l == mn) ? mn : '0;
          hmarks[0] <= (new_hi && hi_ok && cur_h == mx) ? mx : '0;
          state     <= F_CUT;
        end
        F_CUT: begin
          if (!cut_more) begin
            state <= F_IDLE;
          end else if (!rec_full) begin
            lmarks[pos] <= '0;
            hmarks[pos] <= '0;
            pending     <= pending - 1'b1;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/zpt_back.sv */
// Back half of the zigzag pivot tracker: the cutting stage that alternates low
// and high pivots and emits set and clear events. Depends on zpt_pkg.
`timescale 1ns / 1ps

module zpt_back #(
  parameter int PB = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_empty,
  input  logic [2*PB+32:0]    rec_data,
  output logic                rec_pop,
  output logic                ev_push,
  output zpt_pkg::event_t     ev_data,
  input  logic                ev_full
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EVAL = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  localparam logic [1:0] MODE_NEUTRAL = 2'd0;
  localparam logic [1:0] MODE_LOW     = 2'd1;
  localparam logic [1:0] MODE_HIGH    = 2'd2;

  typedef struct packed {
    logic [PB-1:0] low_mark;
    logic [PB-1:0] high_mark;
    logic [31:0]   bar_index;
    logic          last_cut;
  } cut_rec_t;

  logic [1:0]      state;
  cut_rec_t        rec;
  logic [1:0]      mode;
  logic [PB-1:0]   plo_price;
  logic [31:0]     plo_index;
  logic [PB-1:0]   phi_price;
  logic [31:0]     phi_index;
  zpt_pkg::event_t ev_a;
  zpt_pkg::event_t ev_b;
  logic [1:0]      ev_n;
  logic [1:0]      ei;
  zpt_pkg::event_t held;
  logic            held_v;

  logic [1:0]      mode_next;
  logic [PB-1:0]   plo_price_next;
  logic [31:0]     plo_index_next;
  logic [PB-1:0]   phi_price_next;
  logic [31:0]     phi_index_next;
  zpt_pkg::event_t ev_a_next;
  zpt_pkg::event_t ev_b_next;
  logic [1:0]      ev_n_next;
  logic            lm_nz;
  logic            hm_nz;
  logic            can_out;

  assign rec_pop = (state == B_IDLE) && !rec_empty;
  assign can_out = !held_v || !ev_full;

  // Pivot decision for one cut bar.
  always_comb begin
    lm_nz          = (rec.low_mark != '0);
    hm_nz          = (rec.high_mark != '0);
    mode_next      = mode;
    plo_price_next = plo_price;
    plo_index_next = plo_index;
    phi_price_next = phi_price;
    phi_index_next = phi_index;
    ev_n_next      = 2'd0;
    ev_a_next      = '0;
    ev_b_next      = '0;
    case (mode)
      MODE_LOW: begin
        if (lm_nz && rec.low_mark < plo_price && !hm_nz) begin
          ev_a_next      = '{zpt_pkg::KIND_CLEAR, plo_index, 32'd0, 1'b0};
          ev_b_next      = '{zpt_pkg::KIND_SET_LOW, rec.bar_index,
                             32'(rec.low_mark), 1'b0};
          ev_n_next      = 2'd2;
          plo_price_next = rec.low_mark;
          plo_index_next = rec.bar_index;
        end else if (hm_nz && !lm_nz) begin
          ev_a_next      = '{zpt_pkg::KIND_SET_HIGH, rec.bar_index,
                             32'(rec.high_mark), 1'b0};
          ev_n_next      = 2'd1;
          phi_price_next = rec.high_mark;
          phi_index_next = rec.bar_index;
          mode_next      = MODE_HIGH;
        end
      end
      MODE_HIGH: begin
        if (hm_nz && rec.high_mark > phi_price && !lm_nz) begin
          ev_a_next      = '{zpt_pkg::KIND_CLEAR, phi_index, 32'd0, 1'b0};
          ev_b_next      = '{zpt_pkg::KIND_SET_HIGH, rec.bar_index,
                             32'(rec.high_mark), 1'b0};
          ev_n_next      = 2'd2;
          phi_price_next = rec.high_mark;
          phi_index_next = rec.bar_index;
        end else if (lm_nz && !hm_nz) begin
          ev_a_next      = '{zpt_pkg::KIND_SET_LOW, rec.bar_index,
                             32'(rec.low_mark), 1'b0};
          ev_n_next      = 2'd1;
          plo_price_next = rec.low_mark;
          plo_index_next = rec.bar_index;
          mode_next      = MODE_LOW;
        end
      end
      MODE_NEUTRAL: begin
        // First pivot of the series; a low wins over a high on the same bar.
        if (plo_price == '0 && phi_price == '0) begin
          if (hm_nz) begin
            phi_price_next = rec.high_mark;
            phi_index_next = rec.bar_index;
            mode_next      = MODE_HIGH;
          end
          if (lm_nz) begin
            plo_price_next = rec.low_mark;
            plo_index_next = rec.bar_index;
            mode_next      = MODE_LOW;
            ev_a_next      = '{zpt_pkg::KIND_SET_LOW, rec.bar_index,
                               32'(rec.low_mark), 1'b0};
            ev_n_next      = 2'd1;
          end else if (hm_nz) begin
            ev_a_next      = '{zpt_pkg::KIND_SET_HIGH, rec.bar_index,
                               32'(rec.high_mark), 1'b0};
            ev_n_next      = 2'd1;
          end
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Result write: the held event goes out when a newer one replaces it,
  // and with its last flag set when the input's final cut is done.
  always_comb begin
    ev_push = 1'b0;
    ev_data = held;
    if (state == B_EMIT && held_v && !ev_full) begin
      if (ei < ev_n) begin
        ev_push = 1'b1;
      end else if (rec.last_cut) begin
        ev_push            = 1'b1;
        ev_data.last_event = 1'b1;
      end
    end
  end

  // Cutting stage sequencer and pivot state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      mode      <= MODE_NEUTRAL;
      plo_price <= '0;
      plo_index <= '0;
      phi_price <= '0;
      phi_index <= '0;
      held_v    <= 1'b0;
      ev_n      <= '0;
      ei        <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!rec_empty) begin
            rec   <= rec_data;
            state <= B_EVAL;
          end
        end
        B_EVAL: begin
          mode      <= mode_next;
          plo_price <= plo_price_next;
          plo_index <= plo_index_next;
          phi_price <= phi_price_next;
          phi_index <= phi_index_next;
          ev_a      <= ev_a_next;
          ev_b      <= ev_b_next;
          ev_n      <= ev_n_next;
          ei        <= '0;
          state     <= B_EMIT;
        end
        B_EMIT: begin
          if (ei < ev_n) begin
            if (can_out) begin
              held   <= ei[0] ? ev_b : ev_a;
              held_v <= 1'b1;
              ei     <= ei + 1'b1;
            end
          end else if (rec.last_cut) begin
            if (can_out) begin
              held_v <= 1'b0;
              state  <= B_IDLE;
            end
          end else begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/zigzag_pivot_tracker_top.sv */
// Top level of the zigzag pivot tracker: configuration registers, front half,
// record queue, cutting stage and result queue. Depends on zpt_pkg, zpt_fifo,
// zpt_front and zpt_back.
//
//  channel   handshake                 payload
//  --------  ------------------------  -----------------------------------------
//  input     push / full               action, bar_high, bar_low
//  result    pop / empty               event_kind, bar_index, pivot_price,
//                                      last_event
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A bar's window spans min(window_depth, bars seen) bars; the front half scans it
// through the single read port of the window memory one entry a cycle, then hands
// on each delayed bar and takes no new bar until it is idle again. A flush hands
// on every delayed bar. The cutting stage takes a new handed-on bar only when idle.
// Reset is synchronous and clears all control and pivot state; the window
// memory needs no clearing since a fill count limits the scan.
// A full result queue stalls the cutting stage, which in turn stalls the front.
`timescale 1ns / 1ps

module zigzag_pivot_tracker_top #(
  parameter int DEPTH_MAX    = zpt_pkg::DEPTH_MAX_DEF,
  parameter int BACKSTEP_MAX = zpt_pkg::BACKSTEP_MAX_DEF,
  parameter int PRICE_BITS   = zpt_pkg::PRICE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [31:0] bar_high,
  input  logic [31:0] bar_low,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind,
  output logic [31:0] bar_index,
  output logic [31:0] pivot_price,
  output logic        last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int REC_W = 2 * PRICE_BITS + 33;
  localparam int EV_W  = $bits(zpt_pkg::event_t);

  logic [6:0]       window_depth;
  logic [3:0]       back_step;
  logic [15:0]      tolerance;
  logic             rec_push;
  logic [REC_W-1:0] rec_in;
  logic             rec_full;
  logic             rec_pop;
  logic [REC_W-1:0] rec_out;
  logic             rec_empty;
  logic             ev_push;
  zpt_pkg::event_t  ev_in;
  logic             ev_full;
  zpt_pkg::event_t  ev_out;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_depth <= zpt_pkg::WINDOW_DEPTH_RST;
      back_step    <= zpt_pkg::BACK_STEP_RST;
      tolerance    <= zpt_pkg::TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        zpt_pkg::REG_WINDOW_DEPTH: window_depth <= cfg_data[6:0];
        zpt_pkg::REG_BACK_STEP:    back_step    <= cfg_data[3:0];
        zpt_pkg::REG_TOLERANCE:    tolerance    <= cfg_data;
        default: begin
          tolerance <= tolerance;
        end
      endcase
    end
  end

  // Window scan and marking.
  zpt_front #(
    .DMAX (DEPTH_MAX),
    .BMAX (BACKSTEP_MAX),
    .PB   (PRICE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .action       (action),
    .bar_high     (bar_high),
    .bar_low      (bar_low),
    .full         (full),
    .window_depth (window_depth),
    .back_step    (back_step),
    .tolerance    (tolerance),
    .rec_push     (rec_push),
    .rec_data     (rec_in),
    .rec_full     (rec_full)
  );

  // Queue of delayed bars waiting for the cutting stage.
  zpt_fifo #(
    .WIDTH (REC_W),
    .DEPTH (zpt_pkg::REC_Q_DEPTH)
  ) u_rec_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .din   (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (rec_out),
    .empty (rec_empty)
  );

  // Cutting stage.
  zpt_back #(
    .PB (PRICE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_empty (rec_empty),
    .rec_data  (rec_out),
    .rec_pop   (rec_pop),
    .ev_push   (ev_push),
    .ev_data   (ev_in),
    .ev_full   (ev_full)
  );

  // Result queue.
  zpt_fifo #(
    .WIDTH (EV_W),
    .DEPTH (zpt_pkg::EVT_Q_DEPTH)
  ) u_evt_q (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .din   (ev_in),
    .full  (ev_full),
    .pop   (pop),
    .dout  (ev_out),
    .empty (empty)
  );

  assign event_kind  = ev_out.event_kind;
  assign bar_index   = ev_out.bar_index;
  assign pivot_price = ev_out.pivot_price;
  assign last_event  = ev_out.last_event;

endmodule

/* hw/rtl/zpt_checker.sv */
// Port-level checks for the zigzag pivot tracker, bound to the top level.
// Depends on zpt_pkg and zigzag_pivot_tracker_top.
`timescale 1ns / 1ps

module zpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  event_kind,
  input logic [31:0] pivot_price
);

  // After reset the block takes input and has no result waiting.
  a_reset_state: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("block not idle after reset");

  // A clear event carries no price.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind == zpt_pkg::KIND_CLEAR) |-> pivot_price == 32'd0)
    else $error("clear event with nonzero price");

  // Only the three defined event kinds appear.
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (event_kind == zpt_pkg::KIND_SET_LOW ||
                event_kind == zpt_pkg::KIND_SET_HIGH ||
                event_kind == zpt_pkg::KIND_CLEAR))
    else $error("undefined event kind");

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(event_kind) && $stable(pivot_price))
    else $error("waiting result changed");

endmodule

bind zigzag_pivot_tracker_top zpt_checker u_zpt_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .event_kind  (event_kind),
  .pivot_price (pivot_price)
);
